// ===== design/u8lb_pkg.sv =====
// ---------------------------------------------------------------------------
// u8lb_pkg: shared types for the utf-8 to low-byte decoder
// job record passed from the decode front end through the queue to the
// beat sequencer
// ---------------------------------------------------------------------------
package u8lb_pkg;

  localparam int unsigned JOB_BEATS = 4;   // most output beats one input byte can cause
  localparam int unsigned BYTE_W    = 8;

  // one decoded input byte: up to four output bytes, played out in order
  typedef struct packed {
    logic [JOB_BEATS-1:0][BYTE_W-1:0] bytes;  // beat 0 in the lowest slot
    logic [2:0]                       cnt;    // number of beats, 1..4
    logic                             last;   // final beat closes the stream
    logic                             bare;   // single end marker beat, no data
  } job_t;

endpackage

// ===== design/u8lb_front.sv =====
// ---------------------------------------------------------------------------
// u8lb_front: utf-8 decode front end
// holds the sequence state, classifies each input byte and builds a job
// ---------------------------------------------------------------------------
module u8lb_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            q_full,
  output logic            push,
  output u8lb_pkg::job_t  job
);

  localparam logic [7:0]  REPL_BYTE   = 8'hFD;
  localparam logic [7:0]  HI_SURR_OFS = 8'hC0;     // low byte of 0xd7c0
  localparam logic [20:0] BOM_CP      = 21'h00FEFF;
  localparam logic [20:0] MIN_2B      = 21'h000080;
  localparam logic [20:0] MIN_3B      = 21'h000800;
  localparam logic [20:0] MIN_4B      = 21'h010000;
  localparam logic [20:0] SURR_LO     = 21'h00D800;
  localparam logic [20:0] SURR_HI     = 21'h00DFFF;
  localparam logic [20:0] NONCH_LO    = 21'h00FDD0;
  localparam logic [20:0] NONCH_HI    = 21'h00FDDF;
  localparam logic [20:0] CP_LIMIT    = 21'h110000;

  localparam logic [1:0]  SEQ_2B = 2'd1;
  localparam logic [1:0]  SEQ_3B = 2'd2;
  localparam logic [1:0]  SEQ_4B = 2'd3;

  logic [1:0]  need_r, need_nxt;
  logic [1:0]  seq_r, seq_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic        hdr_r, hdr_nxt;

  logic        acc_beat;
  logic        seq_open;
  logic        is_cont;
  logic        do_fresh;
  logic        do_finish;
  logic [1:0]  pre;
  logic [1:0]  post;
  logic [1:0]  main_n;
  logic [7:0]  m0;
  logic [7:0]  m1;
  logic [20:0] uc;
  logic [20:0] min_uc;
  logic        nonchar;
  logic [2:0]  cnt;

  assign in_ready = !q_full;
  assign acc_beat = in_valid && in_ready;
  assign seq_open = (need_r != 2'd0);
  assign is_cont  = (in_byte[7:6] == 2'b10);

  always_comb begin
    need_nxt  = need_r;
    seq_nxt   = seq_r;
    acc_nxt   = acc_r;
    hdr_nxt   = hdr_r;
    pre       = 2'd0;
    post      = 2'd0;
    main_n    = 2'd0;
    m0        = 8'h00;
    m1        = 8'h00;
    do_fresh  = 1'b0;
    do_finish = 1'b0;
    uc        = 21'd0;
    min_uc    = MIN_4B;
    nonchar   = 1'b0;

    if (seq_open && is_cont) begin
      acc_nxt  = {acc_r[14:0], in_byte[5:0]};
      need_nxt = need_r - 2'd1;
      if (need_nxt == 2'd0) begin
        do_finish = 1'b1;
      end
    end else if (seq_open) begin
      // broken sequence: one replacement per byte taken, then retry the byte
      pre      = seq_r - need_r + 2'd1;
      need_nxt = 2'd0;
      hdr_nxt  = 1'b1;
      do_fresh = 1'b1;
    end else begin
      do_fresh = 1'b1;
    end

    if (do_fresh) begin
      if (in_byte[7] == 1'b0) begin
        main_n  = 2'd1;
        m0      = in_byte;
        hdr_nxt = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        acc_nxt  = {16'd0, in_byte[4:0]};
        need_nxt = SEQ_2B;
        seq_nxt  = SEQ_2B;
        hdr_nxt  = 1'b1;
      end else if (in_byte[7:4] == 4'b1110) begin
        // a three-byte lead may still start a byte order mark
        acc_nxt  = {17'd0, in_byte[3:0]};
        need_nxt = SEQ_3B;
        seq_nxt  = SEQ_3B;
      end else if (in_byte[7:3] == 5'b11110) begin
        acc_nxt  = {18'd0, in_byte[2:0]};
        need_nxt = SEQ_4B;
        seq_nxt  = SEQ_4B;
        hdr_nxt  = 1'b1;
      end else begin
        main_n  = 2'd1;
        m0      = REPL_BYTE;
        hdr_nxt = 1'b1;
      end
    end

    if (do_finish) begin
      uc = acc_nxt;
      case (seq_r)
        SEQ_2B:  min_uc = MIN_2B;
        SEQ_3B:  min_uc = MIN_3B;
        default: min_uc = MIN_4B;
      endcase
      nonchar = (uc[15:1] == 15'h7FFF) || (uc >= NONCH_LO && uc <= NONCH_HI);
      if (!hdr_r && uc == BOM_CP) begin
        main_n = 2'd0;
      end else if (!nonchar && uc >= MIN_4B && uc < CP_LIMIT) begin
        // surrogate pair, low byte of each half
        main_n = 2'd2;
        m0     = uc[17:10] + HI_SURR_OFS;
        m1     = uc[7:0];
      end else if (uc < min_uc || (uc >= SURR_LO && uc <= SURR_HI) || nonchar
                   || uc >= CP_LIMIT) begin
        main_n = 2'd1;
        m0     = REPL_BYTE;
      end else begin
        main_n = 2'd1;
        m0     = uc[7:0];
      end
      hdr_nxt = 1'b1;
    end

    if (in_last) begin
      if (need_nxt != 2'd0) begin
        post = seq_nxt - need_nxt + 2'd1;
      end
      need_nxt = 2'd0;
      seq_nxt  = 2'd0;
      acc_nxt  = 21'd0;
      hdr_nxt  = 1'b0;
    end
  end

  assign cnt = {1'b0, pre} + {1'b0, main_n} + {1'b0, post};

  always_comb begin
    job.last = in_last;
    job.bare = (cnt == 3'd0);
    job.cnt  = (cnt == 3'd0) ? 3'd1 : cnt;
    for (int i = 0; i < u8lb_pkg::JOB_BEATS; i++) begin
      if (cnt == 3'd0) begin
        job.bytes[i] = 8'h00;
      end else if (main_n != 2'd0 && {1'b0, pre} == 3'(i)) begin
        job.bytes[i] = m0;
      end else if (main_n == 2'd2 && ({1'b0, pre} + 3'd1) == 3'(i)) begin
        job.bytes[i] = m1;
      end else begin
        job.bytes[i] = REPL_BYTE;
      end
    end
  end

  assign push = acc_beat && (cnt != 3'd0 || in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= 2'd0;
      seq_r  <= 2'd0;
      acc_r  <= 21'd0;
      hdr_r  <= 1'b0;
    end else if (acc_beat) begin
      need_r <= need_nxt;
      seq_r  <= seq_nxt;
      acc_r  <= acc_nxt;
      hdr_r  <= hdr_nxt;
    end
  end

  // the end of a stream puts the decoder back to its start state
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_beat && in_last) |=> (need_r == 2'd0 && !hdr_r))
    else $error("decoder state not cleared after last beat");

  // an open sequence never claims more bytes than its lead announced
  a_need_le_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (need_r != 2'd0) |-> (need_r <= seq_r))
    else $error("pending count exceeds sequence length");

endmodule

// ===== design/u8lb_queue.sv =====
// ---------------------------------------------------------------------------
// u8lb_queue: job queue
// small register queue that decouples the decode front end from the
// beat sequencer
// ---------------------------------------------------------------------------
module u8lb_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u8lb_pkg::job_t  push_job,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output u8lb_pkg::job_t  head
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8lb_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("job queue underflow");

endmodule

// ===== design/u8lb_back.sv =====
// ---------------------------------------------------------------------------
// u8lb_back: beat sequencer
// plays each queued job out as one output beat per cycle, while out_tready
// allows, into a registered output stage
// ---------------------------------------------------------------------------
module u8lb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  u8lb_pkg::job_t  head,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tuser,
  output logic            out_tlast
);

  logic [1:0] idx_r;
  logic       vld_r;
  logic [7:0] data_r;
  logic       user_r;
  logic       last_r;
  logic       load;
  logic       final_beat;

  assign load       = q_valid && (!vld_r || out_tready);
  assign final_beat = ({1'b0, idx_r} == (head.cnt - 3'd1));
  assign pop        = load && final_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= final_beat ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= head.bytes[idx_r];
      user_r <= !head.bare;
      last_r <= head.last && final_beat;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

  // a beat without data is only ever the end marker
  a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !user_r) |-> last_r)
    else $error("data-less beat without end marker");

  // every queued job carries at least one beat
  a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (head.cnt != 3'd0 && head.cnt <= 3'd4))
    else $error("job with bad beat count");

endmodule

// ===== design/utf8_decode_to_low_bytes_unit.sv =====
// ---------------------------------------------------------------------------
// utf8_decode_to_low_bytes_unit: utf-8 decoder giving utf-16 low bytes
// streams utf-8 bytes in, streams the low byte of each utf-16 code unit out
// ---------------------------------------------------------------------------
// One utf-8 byte enters per input beat. Each completed code point comes out
// as the low byte of its utf-16 form: one beat below 0x10000, two beats (low
// bytes of the high and low surrogate) above. Overlong forms, surrogates,
// non-characters, values past 0x10ffff and stray bytes give 0xfd; a broken
// sequence gives one 0xfd per byte it had taken and the offending byte is
// then decoded afresh. A byte order mark at the start of a stream is dropped.
// in_tlast ends the stream: any open sequence is flushed as 0xfd beats, the
// final output beat carries out_tlast, and if the last byte gave nothing a
// single beat with out_tuser low marks the end. The block sustains one input
// beat per cycle while out_tready is high and each byte yields at most one
// output beat; a byte with more beats holds the output sequencer until all
// are out, and the job queue of QUEUE_DEPTH entries absorbs such bursts
// before in_tready drops. Each job passes a queue entry and the output register.
// ---------------------------------------------------------------------------
module utf8_decode_to_low_bytes_unit #(
  parameter int unsigned QUEUE_DEPTH = 4   // jobs buffered, at least 2
) (
  input  logic       clk,
  input  logic       rst_n,

  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,    // is_last

  // output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tuser,   // [0] byte_valid
  output logic       out_tlast    // stream_end
);

  // front end to queue
  logic           push;
  u8lb_pkg::job_t push_job;
  logic           q_full;

  // queue to sequencer
  logic           q_valid;
  logic           pop;
  u8lb_pkg::job_t head;

  // decode: sequence state, validity checks, job building
  u8lb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  // decouples decode from beat play-out
  u8lb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  // one output beat per cycle from the head job while out_tready allows
  u8lb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
